// File: hw/rtl/ame_pkg.sv
// ----------------------------------------------------------------------------
// ame_pkg
// shared opcodes, fault codes, cost constants and helpers for the
// accumulator machine executor
// ----------------------------------------------------------------------------
package ame_pkg;

    localparam int unsigned DATA_DEPTH_DEF = 4096;
    localparam int unsigned PROG_DEPTH_DEF = 65536;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned PC_W   = 16;
    localparam int unsigned LEN_W  = 17;
    localparam int unsigned CNT_W  = 63;
    localparam int unsigned COST_W = 7;
    localparam int unsigned CMD_W  = 5;

    // opcodes
    localparam logic [CMD_W-1:0] OP_GET    = 5'd0;
    localparam logic [CMD_W-1:0] OP_PUT    = 5'd1;
    localparam logic [CMD_W-1:0] OP_LOAD   = 5'd2;
    localparam logic [CMD_W-1:0] OP_STORE  = 5'd3;
    localparam logic [CMD_W-1:0] OP_LOADI  = 5'd4;
    localparam logic [CMD_W-1:0] OP_STOREI = 5'd5;
    localparam logic [CMD_W-1:0] OP_ADD    = 5'd6;
    localparam logic [CMD_W-1:0] OP_SUB    = 5'd7;
    localparam logic [CMD_W-1:0] OP_ADDI   = 5'd8;
    localparam logic [CMD_W-1:0] OP_SUBI   = 5'd9;
    localparam logic [CMD_W-1:0] OP_SET    = 5'd10;
    localparam logic [CMD_W-1:0] OP_HALF   = 5'd11;
    localparam logic [CMD_W-1:0] OP_JUMP   = 5'd12;
    localparam logic [CMD_W-1:0] OP_JPOS   = 5'd13;
    localparam logic [CMD_W-1:0] OP_JZERO  = 5'd14;
    localparam logic [CMD_W-1:0] OP_JUMPI  = 5'd15;
    localparam logic [CMD_W-1:0] OP_HALT   = 5'd16;

    // fault codes
    localparam logic [1:0] FAULT_NONE = 2'd0;
    localparam logic [1:0] FAULT_NEG  = 2'd1;
    localparam logic [1:0] FAULT_JUMP = 2'd2;
    localparam logic [1:0] FAULT_ADDR = 2'd3;

    // costs
    localparam logic [COST_W-1:0] COST_NONE = 7'd0;
    localparam logic [COST_W-1:0] COST_IO   = 7'd100;
    localparam logic [COST_W-1:0] COST_MEM  = 7'd10;
    localparam logic [COST_W-1:0] COST_HALF = 7'd5;
    localparam logic [COST_W-1:0] COST_JUMP = 7'd1;

    // outcome of one instruction
    typedef struct packed {
        logic                commit;
        logic                halt;
        logic [1:0]          fault;
        logic                wr_en;
        logic                wr_acc;
        logic                wr_ptr;
        logic [WORD_W-1:0]   wr_data;
        logic [PC_W-1:0]     pc_next;
        logic                put_valid;
        logic [WORD_W-1:0]   put_value;
        logic [COST_W-1:0]   cost;
        logic [COST_W-1:0]   io_cost;
    } exec_res_t;

    function automatic logic addr_ok(input logic [WORD_W-1:0] a, input int unsigned depth);
        return !a[WORD_W-1] && (a < WORD_W'(depth));
    endfunction

    function automatic logic is_indirect(input logic [CMD_W-1:0] c);
        return (c == OP_LOADI) || (c == OP_STOREI) || (c == OP_ADDI) || (c == OP_SUBI);
    endfunction

    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [COST_W-1:0] b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + (CNT_W+1)'(b);
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

endpackage

// File: hw/rtl/ame_exec.sv
// ----------------------------------------------------------------------------
// ame_exec
// decode and execute of one instruction once its memory operands are known
// ----------------------------------------------------------------------------
module ame_exec
    import ame_pkg::*;
#(
    parameter int unsigned DATA_DEPTH = DATA_DEPTH_DEF,
    parameter int unsigned PROG_DEPTH = PROG_DEPTH_DEF
)
(
    input  logic [CMD_W-1:0]  cmd,
    input  logic [WORD_W-1:0] operand,
    input  logic [WORD_W-1:0] get_value,
    input  logic [WORD_W-1:0] acc,
    input  logic [WORD_W-1:0] word_a,      // memory word at operand
    input  logic [WORD_W-1:0] word_b,      // memory word at pointer
    input  logic [PC_W-1:0]   pc,
    input  logic [LEN_W-1:0]  prog_len,
    input  logic              stopped,
    output exec_res_t         res
);

    logic [LEN_W-1:0]  len;
    logic              indirect;
    logic              uses_addr;
    logic [WORD_W-1:0] b_val;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] diff;
    logic              ge;
    logic [WORD_W-1:0] half_v;
    logic [WORD_W-1:0] seq;
    logic [WORD_W-1:0] target;
    logic              wr_en;
    logic              wr_acc;
    logic              wr_ptr;
    logic [WORD_W-1:0] wr_data;
    logic              put_en;
    logic [COST_W-1:0] cost;
    logic [COST_W-1:0] io_cost;

    assign len       = (prog_len > LEN_W'(PROG_DEPTH)) ? LEN_W'(PROG_DEPTH) : prog_len;
    assign indirect  = is_indirect(cmd);
    assign uses_addr = (cmd <= OP_SUBI) || (cmd == OP_JUMPI);
    assign b_val     = indirect ? word_b : word_a;
    assign sum       = acc + b_val;
    assign diff      = acc - b_val;
    assign ge        = $signed(acc) >= $signed(b_val);
    // truncate toward zero: bias negative values by one before the shift
    assign half_v    = WORD_W'($signed(acc + WORD_W'(acc[WORD_W-1])) >>> 1);
    assign seq       = WORD_W'(pc) + WORD_W'(1);

    // branch target and cost
    always_comb
    begin
        target  = seq;
        cost    = COST_NONE;
        io_cost = COST_NONE;
        priority if (cmd == OP_GET || cmd == OP_PUT)
        begin
            cost    = COST_IO;
            io_cost = COST_IO;
        end
        else if (cmd <= OP_SET)
        begin
            cost = COST_MEM;
        end
        else if (cmd == OP_HALF)
        begin
            cost = COST_HALF;
        end
        else if (cmd == OP_JUMP)
        begin
            target = operand;
            cost   = COST_JUMP;
        end
        else if (cmd == OP_JPOS)
        begin
            if (acc != '0 && !acc[WORD_W-1])
                target = operand;
            cost = COST_JUMP;
        end
        else if (cmd == OP_JZERO)
        begin
            if (acc == '0)
                target = operand;
            cost = COST_JUMP;
        end
        else if (cmd == OP_JUMPI)
        begin
            target = word_a;
            cost   = COST_JUMP;
        end
        else
        begin
            // unknown opcode holds the pc
            target = WORD_W'(pc);
        end
    end

    // data effect
    always_comb
    begin
        wr_en   = 1'b0;
        wr_acc  = 1'b0;
        wr_ptr  = 1'b0;
        wr_data = acc;
        put_en  = 1'b0;
        unique case (cmd)
            OP_GET:
            begin
                wr_en   = 1'b1;
                wr_data = get_value;
            end
            OP_PUT:    put_en = 1'b1;
            OP_STORE:  wr_en = 1'b1;
            OP_STOREI:
            begin
                wr_en  = 1'b1;
                wr_ptr = 1'b1;
            end
            OP_LOAD:
            begin
                wr_en   = 1'b1;
                wr_acc  = 1'b1;
                wr_data = word_a;
            end
            OP_LOADI:
            begin
                wr_en   = 1'b1;
                wr_acc  = 1'b1;
                wr_data = word_b;
            end
            OP_ADD, OP_ADDI:
            begin
                wr_en   = 1'b1;
                wr_acc  = 1'b1;
                wr_data = sum;
            end
            OP_SUB, OP_SUBI:
            begin
                wr_en   = 1'b1;
                wr_acc  = 1'b1;
                wr_data = ge ? diff : '0;
            end
            OP_SET:
            begin
                wr_en   = 1'b1;
                wr_acc  = 1'b1;
                wr_data = operand;
            end
            OP_HALF:
            begin
                wr_en   = 1'b1;
                wr_acc  = 1'b1;
                wr_data = half_v;
            end
            default: ;
        endcase
    end

    // checks in order of precedence
    always_comb
    begin
        res           = '0;
        res.wr_acc    = wr_acc;
        res.wr_ptr    = wr_ptr;
        res.wr_data   = wr_data;
        res.pc_next   = target[PC_W-1:0];
        res.put_value = '0;
        res.cost      = cost;
        res.io_cost   = io_cost;
        priority if (stopped)
            res.commit = 1'b0;
        else if (cmd == OP_HALT)
            res.halt = 1'b1;
        else if (operand[WORD_W-1])
            res.fault = FAULT_NEG;
        else if (uses_addr && !addr_ok(operand, DATA_DEPTH))
            res.fault = FAULT_ADDR;
        else if (indirect && !addr_ok(word_a, DATA_DEPTH))
            res.fault = FAULT_ADDR;
        else if (target[WORD_W-1] || target >= WORD_W'(len))
            res.fault = FAULT_JUMP;
        else
            res.commit = 1'b1;
        res.wr_en     = res.commit && wr_en;
        res.put_valid = res.commit && put_en;
        if (res.put_valid)
            res.put_value = word_a;
    end

endmodule

// File: hw/rtl/accumulator_machine_executor_core.sv
// ----------------------------------------------------------------------------
// accumulator_machine_executor_core
// executes one accumulator machine instruction per input transfer
// ----------------------------------------------------------------------------
// Each input transfer carries one instruction fetched at the pc reported by
// the previous result; each instruction gives exactly one result transfer.
// After reset the data memory is swept to zero with s_axis_tready low
// (configuration writes are taken meanwhile). Every memory operand goes
// through the single registered read port of the data memory, so an
// indirect instruction (loadi, storei, addi, subi) makes a second read
// after the operand word, the word at the pointer, before its result is
// registered on the output. The next instruction is taken in the cycle the
// current one writes back, so throughput is one direct instruction per
// cycle while the result side keeps up; the instruction after an indirect
// one is taken only once its second read is done. The accumulator (word 0)
// is held in a register and a write-back bypass covers a read issued in
// the write-back cycle. Once halt or a fault is seen the block is stopped
// until reset and repeats its state.
// ----------------------------------------------------------------------------
module accumulator_machine_executor_core
    import ame_pkg::*;
#(
    parameter int unsigned DATA_DEPTH = DATA_DEPTH_DEF,
    parameter int unsigned PROG_DEPTH = PROG_DEPTH_DEF
)
(
    input  logic          clk,
    input  logic          rst_n,
    // configuration: program_length
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [16:0]   cfg_data,
    // instruction stream
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // operand[63:0], get_value[127:64]
    input  logic [4:0]    s_axis_tuser,   // cmd[4:0]
    // result stream
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [215:0]  m_axis_tdata,   // next_pc[15:0], put_value[79:16],
                                          // halted[80], fault[82:81],
                                          // total_cost[145:83], io_cost[208:146],
                                          // zero pad[215:209]
    output logic          m_axis_tuser    // put_valid
);

    localparam int unsigned AW = $clog2(DATA_DEPTH);

    typedef enum logic {PH_FIRST, PH_SECOND} phase_t;

    // control state
    phase_t            phase_reg;
    logic              busy_reg;
    logic              clearing_reg;
    logic [AW-1:0]     clr_cnt_reg;
    logic [LEN_W-1:0]  prog_len_reg;
    logic [PC_W-1:0]   pc_reg;
    logic [CNT_W-1:0]  total_cost_reg;
    logic [CNT_W-1:0]  io_cost_reg;
    logic              stopped_reg;
    logic [1:0]        stop_code_reg;
    logic [WORD_W-1:0] acc_reg;
    logic              fwd_valid_reg;
    logic              out_valid_reg;

    // payload
    logic [CMD_W-1:0]  cmd_reg;
    logic [WORD_W-1:0] opd_reg;
    logic [WORD_W-1:0] gv_reg;
    logic [WORD_W-1:0] word_a_reg;
    logic [AW-1:0]     rd_addr_reg;
    logic [AW-1:0]     fwd_addr_reg;
    logic [WORD_W-1:0] fwd_data_reg;
    logic [215:0]      out_data_reg;
    logic              out_user_reg;

    // data memory, word 0 shadowed by acc_reg
    logic [WORD_W-1:0] mem [DATA_DEPTH];
    logic [WORD_W-1:0] mem_q;

    logic              out_free;
    logic              need_second;
    logic              finish;
    logic              in_xfer;
    logic              second_issue;
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic [WORD_W-1:0] rd_word;
    logic [WORD_W-1:0] word_a;
    logic [AW-1:0]     wr_addr;
    logic              mem_we;
    logic [AW-1:0]     mem_wa;
    logic [WORD_W-1:0] mem_wd;
    logic              acc_we;
    exec_res_t         res;

    logic [PC_W-1:0]   pc_next;
    logic [CNT_W-1:0]  total_cost_next;
    logic [CNT_W-1:0]  io_cost_next;
    logic              stopped_next;
    logic [1:0]        stop_code_next;

    assign cfg_ready = 1'b1;

    // handshake and sequencing
    assign out_free     = !out_valid_reg || m_axis_tready;
    assign need_second  = is_indirect(cmd_reg) && !stopped_reg && addr_ok(opd_reg, DATA_DEPTH);
    assign finish       = busy_reg && out_free && ((phase_reg == PH_SECOND) || !need_second);
    assign s_axis_tready = !clearing_reg && (!busy_reg || finish);
    assign in_xfer      = s_axis_tvalid && s_axis_tready;
    assign second_issue = busy_reg && (phase_reg == PH_FIRST) && need_second;

    // one read port: operand word on accept, pointer word in the cycle after
    assign rd_en   = in_xfer || second_issue;
    assign rd_addr = in_xfer ? s_axis_tdata[AW-1:0] : rd_word[AW-1:0];

    // read data with accumulator shadow and write-back bypass
    always_comb
    begin
        priority if (rd_addr_reg == '0)
            rd_word = acc_reg;
        else if (fwd_valid_reg && (fwd_addr_reg == rd_addr_reg))
            rd_word = fwd_data_reg;
        else
            rd_word = mem_q;
    end

    assign word_a = (phase_reg == PH_FIRST) ? rd_word : word_a_reg;

    ame_exec #(
        .DATA_DEPTH (DATA_DEPTH),
        .PROG_DEPTH (PROG_DEPTH)
    ) u_exec (
        .cmd       (cmd_reg),
        .operand   (opd_reg),
        .get_value (gv_reg),
        .acc       (acc_reg),
        .word_a    (word_a),
        .word_b    (rd_word),
        .pc        (pc_reg),
        .prog_len  (prog_len_reg),
        .stopped   (stopped_reg),
        .res       (res)
    );

    // write-back routing; address zero lands in the accumulator
    always_comb
    begin
        priority if (res.wr_acc)
            wr_addr = '0;
        else if (res.wr_ptr)
            wr_addr = word_a[AW-1:0];
        else
            wr_addr = opd_reg[AW-1:0];
    end

    assign acc_we = finish && res.wr_en && (wr_addr == '0);
    assign mem_we = clearing_reg || (finish && res.wr_en && (wr_addr != '0));
    assign mem_wa = clearing_reg ? clr_cnt_reg : wr_addr;
    assign mem_wd = clearing_reg ? '0 : res.wr_data;

    // next architectural state
    assign pc_next         = res.commit ? res.pc_next : pc_reg;
    assign total_cost_next = res.commit ? sat_add(total_cost_reg, res.cost) : total_cost_reg;
    assign io_cost_next    = res.commit ? sat_add(io_cost_reg, res.io_cost) : io_cost_reg;
    assign stopped_next    = stopped_reg || res.halt || (res.fault != FAULT_NONE);
    assign stop_code_next  = (res.fault != FAULT_NONE) ? res.fault : stop_code_reg;

    // data memory
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        if (rd_en)
            mem_q <= mem[rd_addr];
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg <= s_axis_tuser;
            opd_reg <= s_axis_tdata[63:0];
            gv_reg  <= s_axis_tdata[127:64];
        end
        if (rd_en)
            rd_addr_reg <= rd_addr;
        if (second_issue)
            word_a_reg <= rd_word;
        if (finish && res.wr_en && (wr_addr != '0))
        begin
            fwd_addr_reg <= wr_addr;
            fwd_data_reg <= res.wr_data;
        end
        if (finish)
        begin
            out_user_reg <= res.put_valid;
            out_data_reg <= {7'd0, io_cost_next, total_cost_next, stop_code_next,
                             stopped_next && (stop_code_next == FAULT_NONE),
                             res.put_value, pc_next};
        end
    end

    // control state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_FIRST;
            busy_reg       <= 1'b0;
            clearing_reg   <= 1'b1;
            clr_cnt_reg    <= '0;
            prog_len_reg   <= LEN_W'(1);
            pc_reg         <= '0;
            total_cost_reg <= '0;
            io_cost_reg    <= '0;
            stopped_reg    <= 1'b0;
            stop_code_reg  <= FAULT_NONE;
            acc_reg        <= '0;
            fwd_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (clearing_reg)
            begin
                clr_cnt_reg <= clr_cnt_reg + AW'(1);
                if (clr_cnt_reg == AW'(DATA_DEPTH - 1))
                    clearing_reg <= 1'b0;
            end

            if (cfg_valid && cfg_ready)
                prog_len_reg <= cfg_data;

            if (in_xfer)
            begin
                busy_reg  <= 1'b1;
                phase_reg <= PH_FIRST;
            end
            else if (finish)
                busy_reg <= 1'b0;
            else if (second_issue)
                phase_reg <= PH_SECOND;

            if (finish)
            begin
                pc_reg         <= pc_next;
                total_cost_reg <= total_cost_next;
                io_cost_reg    <= io_cost_next;
                stopped_reg    <= stopped_next;
                stop_code_reg  <= stop_code_next;
                if (res.wr_en && (wr_addr != '0))
                    fwd_valid_reg <= 1'b1;
            end
            if (acc_we)
                acc_reg <= res.wr_data;

            if (finish)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // a stopped machine never moves its pc
    a_stopped_pc_hold: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> $stable(pc_reg))
        else $error("pc moved after stop");

    // the running total includes every io charge
    a_io_within_total: assert property (@(posedge clk) disable iff (!rst_n)
        io_cost_reg <= total_cost_reg)
        else $error("io cost exceeds total cost");

    // cost counters never go backwards
    a_cost_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |=> (total_cost_reg >= $past(total_cost_reg))
                  && (io_cost_reg >= $past(io_cost_reg)))
        else $error("cost counter decreased");

    // the pointer read happens only for indirect instructions
    a_second_indirect: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && phase_reg == PH_SECOND) |-> is_indirect(cmd_reg))
        else $error("second read for a direct instruction");

    // no instruction is taken while the memory sweep runs
    a_no_issue_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        clearing_reg |-> !busy_reg && !out_valid_reg)
        else $error("instruction active during memory sweep");

endmodule

// File: tb/accumulator_machine_executor_core_tb.sv
// ----------------------------------------------------------------------------
// accumulator_machine_executor_core_tb
// self-checking testbench for the accumulator machine executor
// ----------------------------------------------------------------------------
// Drives instruction transfers and keeps its own model of the machine: data
// memory, pc, cost counters and the sticky stop state. Every accepted
// instruction queues one predicted result, and each result transfer is checked
// field by field against the oldest prediction. The run covers a directed
// sweep of all opcodes, random well-formed programs under several program
// lengths and idle patterns, and ends with one stopping event (halt or a
// fault) followed by noise that the stopped block must ignore.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module accumulator_machine_executor_core_tb;
    import ame_pkg::*;

    localparam int unsigned DATA_WORDS     = DATA_DEPTH_DEF;
    // no transfer at all for this long means a hang; it must outlast the
    // clearing pass after reset
    localparam int unsigned QUIET_LIMIT    = 20000;
    localparam int unsigned SETTLE_CYCLES  = 4;
    localparam int unsigned TAIL_CYCLES    = 16;
    localparam int          PHASE_ITEMS    = 345;
    localparam logic [62:0] COUNT_MAX      = {63{1'b1}};
    localparam logic [63:0] WORD_MAX       = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] SIGN_BIT       = 64'h8000_0000_0000_0000;

    // one predicted result transfer
    typedef struct packed {
        logic [15:0] next_pc;
        logic        put_valid;
        logic [63:0] put_value;
        logic        halted;
        logic [1:0]  fault;
        logic [62:0] total_cost;
        logic [62:0] io_cost;
    } instr_result_t;

    logic          clk;
    logic          rst_n;
    logic          cfg_valid;
    logic          cfg_ready;
    logic [16:0]   cfg_data;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata;   // operand[63:0], get_value[127:64]
    logic [4:0]    s_axis_tuser;   // cmd[4:0]
    logic          m_axis_tvalid;
    logic          m_axis_tready = 1'b0;
    logic [215:0]  m_axis_tdata;   // next_pc[15:0], put_value[79:16], halted[80],
                                   // fault[82:81], total_cost[145:83],
                                   // io_cost[208:146], zero pad[215:209]
    logic          m_axis_tuser;   // put_valid

    // machine state as the testbench sees it
    logic [63:0]   dmem [0:DATA_WORDS-1];
    logic [15:0]   pc_q;
    logic [62:0]   cost_total_q;
    logic [62:0]   cost_io_q;
    bit            stopped_q;
    logic [1:0]    stop_code_q;
    logic [16:0]   prog_len_q;

    instr_result_t pending_results [$];

    int            src_idle_pct   = 0;
    int            sink_stall_pct = 0;
    int            error_count    = 0;
    int            instrs_sent    = 0;
    int            results_seen   = 0;
    int            puts_seen      = 0;
    int            length_writes  = 0;
    int unsigned   quiet_cycles   = 0;
    string         stop_label     = "none";

    accumulator_machine_executor_core uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #2 clk = ~clk;

    // result side backpressure, redrawn every cycle
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // ------------------------------------------------------------------------
    // prediction
    // ------------------------------------------------------------------------

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    function automatic bit in_data_range(input logic [63:0] w);
        return !w[63] && (w < 64'(DATA_WORDS));
    endfunction

    function automatic logic [62:0] add_saturated(input logic [62:0] a, input logic [6:0] b);
        return (a > COUNT_MAX - 63'(b)) ? COUNT_MAX : a + 63'(b);
    endfunction

    // runs one instruction on the model; with commit clear the state is left
    // alone, so the stimulus side can try out candidates
    function automatic instr_result_t execute_instr(input logic [4:0]  cmd,
                                                    input logic [63:0] opd,
                                                    input logic [63:0] gv,
                                                    input bit          commit);
        instr_result_t r;
        logic [63:0]   eff_len;
        logic [63:0]   target;
        logic [63:0]   acc;
        logic [63:0]   b;
        logic [63:0]   ptr;
        logic [63:0]   wr_val;
        logic [63:0]   put_x;
        logic [11:0]   wr_addr;
        logic [6:0]    cost;
        logic [6:0]    io_add;
        logic [1:0]    flt;
        logic [15:0]   n_pc;
        logic [62:0]   n_tot;
        logic [62:0]   n_io;
        logic [1:0]    n_code;
        bit            n_stopped;
        bit            wr_en;
        bit            put_v;
        bit            indirect;
        bit            uses_addr;

        eff_len   = (prog_len_q > 17'd65536) ? 64'd65536 : 64'(prog_len_q);
        target    = 64'(pc_q) + 64'd1;
        acc       = '0;
        b         = '0;
        ptr       = '0;
        wr_val    = '0;
        put_x     = '0;
        wr_addr   = '0;
        cost      = COST_NONE;
        io_add    = COST_NONE;
        flt       = FAULT_NONE;
        wr_en     = 1'b0;
        put_v     = 1'b0;
        indirect  = (cmd == OP_LOADI) || (cmd == OP_STOREI) ||
                    (cmd == OP_ADDI) || (cmd == OP_SUBI);
        uses_addr = (cmd <= OP_SUBI) || (cmd == OP_JUMPI);
        n_pc      = pc_q;
        n_tot     = cost_total_q;
        n_io      = cost_io_q;
        n_code    = stop_code_q;
        n_stopped = stopped_q;

        if (!stopped_q)
        begin
            if (cmd == OP_HALT)
                n_stopped = 1'b1;
            else if (opd[63])
                flt = FAULT_NEG;
            else if (uses_addr && !in_data_range(opd))
                flt = FAULT_ADDR;
            else
            begin
                if (indirect)
                begin
                    ptr = dmem[opd[11:0]];
                    if (!in_data_range(ptr))
                        flt = FAULT_ADDR;
                end
                acc = dmem[0];
                if (flt == FAULT_NONE)
                begin
                    case (cmd)
                        OP_GET, OP_PUT:
                        begin
                            cost   = COST_IO;
                            io_add = COST_IO;
                        end
                        OP_JUMP:
                        begin
                            target = opd;
                            cost   = COST_JUMP;
                        end
                        OP_JPOS:
                        begin
                            if (acc != 64'd0 && !acc[63])
                                target = opd;
                            cost = COST_JUMP;
                        end
                        OP_JZERO:
                        begin
                            if (acc == 64'd0)
                                target = opd;
                            cost = COST_JUMP;
                        end
                        OP_JUMPI:
                        begin
                            target = dmem[opd[11:0]];
                            cost   = COST_JUMP;
                        end
                        OP_HALF:
                            cost = COST_HALF;
                        default:
                        begin
                            // memory opcodes cost COST_MEM; unknown opcodes stay on the same pc
                            if (cmd <= OP_SET)
                                cost = COST_MEM;
                            else
                                target = 64'(pc_q);
                        end
                    endcase
                    if (target[63] || target >= eff_len)
                        flt = FAULT_JUMP;
                end
                if (flt == FAULT_NONE)
                begin
                    wr_en = 1'b1;
                    case (cmd)
                        OP_GET:
                        begin
                            wr_addr = opd[11:0];
                            wr_val  = gv;
                        end
                        OP_PUT:
                        begin
                            wr_en = 1'b0;
                            put_v = 1'b1;
                            put_x = dmem[opd[11:0]];
                        end
                        OP_LOAD:   wr_val = dmem[opd[11:0]];
                        OP_STORE:
                        begin
                            wr_addr = opd[11:0];
                            wr_val  = acc;
                        end
                        OP_LOADI:  wr_val = dmem[ptr[11:0]];
                        OP_STOREI:
                        begin
                            wr_addr = ptr[11:0];
                            wr_val  = acc;
                        end
                        OP_ADD:    wr_val = acc + dmem[opd[11:0]];
                        OP_ADDI:   wr_val = acc + dmem[ptr[11:0]];
                        OP_SUB, OP_SUBI:
                        begin
                            // stops at zero when the subtrahend is larger
                            b      = dmem[(cmd == OP_SUB) ? opd[11:0] : ptr[11:0]];
                            wr_val = ($signed(acc) >= $signed(b)) ? acc - b : 64'd0;
                        end
                        OP_SET:    wr_val = opd;
                        OP_HALF:
                            wr_val = acc[63] ? 64'd0 - ((64'd0 - acc) >> 1) : acc >> 1;
                        default:   wr_en = 1'b0;
                    endcase
                    n_pc  = target[15:0];
                    n_tot = add_saturated(cost_total_q, cost);
                    n_io  = add_saturated(cost_io_q, io_add);
                end
            end
            if (flt != FAULT_NONE)
            begin
                n_stopped = 1'b1;
                n_code    = flt;
            end
        end

        r.next_pc    = n_pc;
        r.put_valid  = put_v;
        r.put_value  = put_x;
        r.halted     = n_stopped && (n_code == FAULT_NONE);
        r.fault      = n_code;
        r.total_cost = n_tot;
        r.io_cost    = n_io;

        if (commit)
        begin
            if (wr_en)
                dmem[wr_addr] = wr_val;
            pc_q         = n_pc;
            cost_total_q = n_tot;
            cost_io_q    = n_io;
            stopped_q    = n_stopped;
            stop_code_q  = n_code;
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // checking
    // ------------------------------------------------------------------------

    function automatic int field_mismatch(input string       name,
                                          input logic [63:0] expected,
                                          input logic [63:0] actual);
        if (expected !== actual)
        begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expected, actual);
            return 1;
        end
        return 0;
    endfunction

    // sampled on the falling edge: the transfer completes on the next rising
    // edge and nothing changes in between
    always @(negedge clk)
    begin
        instr_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (m_axis_tuser === 1'b1)
                puts_seen++;
            if (pending_results.size() == 0)
            begin
                $error("result transfer with no instruction outstanding");
                error_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                error_count += field_mismatch("next_pc", 64'(want.next_pc),
                                              64'(m_axis_tdata[15:0]));
                error_count += field_mismatch("put_valid", 64'(want.put_valid),
                                              64'(m_axis_tuser));
                error_count += field_mismatch("put_value", want.put_value,
                                              m_axis_tdata[79:16]);
                error_count += field_mismatch("halted", 64'(want.halted),
                                              64'(m_axis_tdata[80]));
                error_count += field_mismatch("fault", 64'(want.fault),
                                              64'(m_axis_tdata[82:81]));
                error_count += field_mismatch("total_cost", 64'(want.total_cost),
                                              64'(m_axis_tdata[145:83]));
                error_count += field_mismatch("io_cost", 64'(want.io_cost),
                                              64'(m_axis_tdata[208:146]));
            end
        end
    end

    // watchdog: any transfer on any channel counts as progress
    always @(negedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------

    // predicts the result, then holds the instruction until it is taken;
    // tvalid stays high if the caller sends the next one right away
    task automatic send_instr(input logic [4:0] cmd, input logic [63:0] opd,
                              input logic [63:0] gv);
        bit taken;
        pending_results.push_back(execute_instr(cmd, opd, gv, 1'b1));
        instrs_sent++;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {gv, opd};
        s_axis_tuser  <= cmd;
        do
        begin
            @(negedge clk);
            taken = s_axis_tready;
            @(posedge clk);
        end
        while (!taken);
    endtask

    // always advances the clock before returning so a following tvalid rise never
    // shares a time step with the drop before it
    task automatic wait_drained();
        do
            @(posedge clk);
        while (pending_results.size() != 0);
    endtask

    // brings the pc home first so a shorter program does not trip the
    // sequential-pc check, then writes the register with the block idle
    task automatic write_program_length(input logic [16:0] len);
        bit taken;
        wait_drained();
        if (pc_q != 16'd0 && !stopped_q)
        begin
            send_instr(OP_JUMP, 64'd0, 64'd0);
            s_axis_tvalid <= 1'b0;
            wait_drained();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= len;
        do
        begin
            @(negedge clk);
            taken = cfg_ready;
            @(posedge clk);
        end
        while (!taken);
        cfg_valid <= 1'b0;
        prog_len_q = len;
        length_writes++;
    endtask

    // mostly a small working set so loads hit stored words
    function automatic logic [63:0] pick_addr();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 7)
            return 64'($urandom_range(15));
        else if (sel < 9)
            return 64'($urandom_range(DATA_WORDS - 1));
        else
            return $urandom_range(1) ? 64'(DATA_WORDS - 1) : 64'd0;
    endfunction

    function automatic logic [63:0] pick_set_value();
        int unsigned sel;
        sel = $urandom_range(9);
        if (sel < 4)
            return 64'($urandom_range(15));
        else if (sel < 7)
            return 64'($urandom_range(DATA_WORDS - 1));
        else
            return rand_word() >> 1;
    endfunction

    // draws candidates until one runs cleanly on the model, so the machine
    // keeps executing; falls back to a jump, which is always legal
    task automatic pick_instr(output logic [4:0] cmd, output logic [63:0] opd,
                              output logic [63:0] gv);
        instr_result_t trial;
        int unsigned   sel;
        bit            found;
        found = 1'b0;
        for (int k = 0; k < 24 && !found; k++)
        begin
            sel = $urandom_range(99);
            gv  = $urandom_range(1) ? rand_word() : 64'($urandom_range(DATA_WORDS - 1));
            opd = pick_addr();
            if (sel < 8)
                cmd = OP_GET;
            else if (sel < 14)
                cmd = OP_PUT;
            else if (sel < 50)
                cmd = 5'($urandom_range(OP_LOAD, OP_SUBI));
            else if (sel < 64)
            begin
                cmd = OP_SET;
                opd = pick_set_value();
            end
            else if (sel < 70)
            begin
                cmd = OP_HALF;
                opd = rand_word() >> 1;
            end
            else if (sel < 95)
            begin
                cmd = 5'($urandom_range(OP_JUMP, OP_JUMPI));
                if (cmd != OP_JUMPI)
                    opd = 64'($urandom_range(prog_len_q - 1));
            end
            else
            begin
                cmd = 5'($urandom_range(17, 31));
                opd = rand_word() >> 1;
            end
            trial = execute_instr(cmd, opd, gv, 1'b0);
            found = (trial.fault == FAULT_NONE) && !trial.halted;
        end
        if (!found)
        begin
            cmd = OP_JUMP;
            opd = 64'($urandom_range(prog_len_q - 1));
        end
    endtask

    // ------------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------------

    // every opcode but halt, address and value extremes, wrap and clamp cases
    task automatic test_directed_ops();
        write_program_length(17'd65536);
        send_instr(OP_GET, 64'd1, -64'd7);          // negative input word
        send_instr(OP_PUT, 64'd1, 64'd0);
        send_instr(OP_LOAD, 64'd1, 64'd0);
        send_instr(OP_HALF, 64'd0, 64'd0);          // -7 halves to -3
        send_instr(OP_STORE, 64'(DATA_WORDS - 1), 64'd0);
        send_instr(OP_SET, 64'(DATA_WORDS - 1), 64'd0);
        send_instr(OP_STORE, 64'd3, 64'd0);         // word 3 points at the top word
        send_instr(OP_LOADI, 64'd3, 64'd0);
        send_instr(OP_SET, 64'd7, 64'd0);
        send_instr(OP_STOREI, 64'd3, 64'd0);
        send_instr(OP_SET, WORD_MAX, 64'd0);
        send_instr(OP_ADDI, 64'd3, 64'd0);          // add wraps negative
        send_instr(OP_SUBI, 64'd3, 64'd0);          // smaller minuend clamps to zero
        send_instr(OP_SET, 64'd9, 64'd0);
        send_instr(OP_SUB, 64'd1, 64'd0);           // minus a negative word
        send_instr(OP_SET, WORD_MAX, 64'd0);
        send_instr(OP_SUB, 64'd1, 64'd0);           // difference wraps
        send_instr(OP_SET, 64'd11, 64'd0);
        send_instr(OP_HALF, 64'd0, 64'd0);          // odd positive
        send_instr(OP_ADD, 64'd1, 64'd0);
        send_instr(OP_JPOS, 64'd9, 64'd0);          // negative acc, not taken
        send_instr(OP_SET, 64'd0, 64'd0);
        send_instr(OP_JZERO, 64'd65535, 64'd0);     // last pc of a full program
        send_instr(OP_JUMP, 64'd0, 64'd0);
        send_instr(OP_SET, 64'd1, 64'd0);
        send_instr(OP_JPOS, 64'd40, 64'd0);
        send_instr(OP_JUMPI, 64'd3, 64'd0);
        send_instr(5'd31, 64'd0, 64'd0);            // unknown opcode does nothing
        s_axis_tvalid <= 1'b0;
    endtask

    // random well-formed program with one full drain halfway through
    task automatic test_random_program(input int n_instrs, input logic [16:0] len,
                                       input int src_pct, input int sink_pct);
        logic [4:0]  cmd;
        logic [63:0] opd;
        logic [63:0] gv;
        write_program_length(len);
        src_idle_pct   = src_pct;
        sink_stall_pct = sink_pct;
        for (int i = 0; i < n_instrs; i++)
        begin
            if (i == n_instrs / 2)
            begin
                s_axis_tvalid <= 1'b0;
                wait_drained();
            end
            pick_instr(cmd, opd, gv);
            send_instr(cmd, opd, gv);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // one stopping event drawn at random, then noise the block must ignore
    task automatic test_stop_and_freeze();
        int unsigned sel;
        logic [4:0]  cmd;
        logic [63:0] opd;
        src_idle_pct   = 11;
        sink_stall_pct = 11;
        // leave an out-of-range pointer in word 5
        write_program_length(17'd8);
        send_instr(OP_SET, (rand_word() >> 1) | 64'h1000, 64'd0);
        send_instr(OP_STORE, 64'd5, 64'd0);
        s_axis_tvalid <= 1'b0;
        // a one-instruction program: any fall-through from pc 0 leaves it
        write_program_length(17'd1);
        case ($urandom_range(4))
            0:
            begin
                stop_label = "halt";
                send_instr(OP_HALT, rand_word(), rand_word());
            end
            1:
            begin
                stop_label = "negative operand";
                cmd = 5'($urandom_range(31));
                if (cmd == OP_HALT)
                    cmd = OP_SET;
                send_instr(cmd, rand_word() | SIGN_BIT, rand_word());
            end
            2:
            begin
                stop_label = "jump target out of program";
                if ($urandom_range(1))
                    send_instr(OP_JUMP, (rand_word() >> 1) | 64'd1, 64'd0);
                else
                    send_instr(OP_SET, rand_word() >> 1, 64'd0);
            end
            3:
            begin
                stop_label = "direct address out of memory";
                cmd = $urandom_range(1) ? OP_JUMPI : 5'($urandom_range(OP_GET, OP_SUBI));
                send_instr(cmd, (rand_word() >> 1) | 64'h1000, rand_word());
            end
            default:
            begin
                stop_label = "pointer out of memory";
                sel = $urandom_range(3);
                cmd = (sel == 0) ? OP_LOADI : (sel == 1) ? OP_STOREI :
                      (sel == 2) ? OP_ADDI : OP_SUBI;
                send_instr(cmd, 64'd5, 64'd0);
            end
        endcase
        // fully random fields, sign bits included
        repeat (30) send_instr(5'($urandom), rand_word(), rand_word());
        s_axis_tvalid <= 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        for (int i = 0; i < DATA_WORDS; i++)
            dmem[i] = 64'd0;
        pc_q         = '0;
        cost_total_q = '0;
        cost_io_q    = '0;
        stopped_q    = 1'b0;
        stop_code_q  = FAULT_NONE;
        prog_len_q   = 17'd1;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        test_directed_ops();
        test_random_program(PHASE_ITEMS, 17'd65536, 0, 0);
        test_random_program(PHASE_ITEMS, 17'd2, 48, 0);
        test_random_program(PHASE_ITEMS, 17'd37, 0, 48);
        test_random_program(PHASE_ITEMS, 17'($urandom_range(3, 65535)), 11, 11);
        test_stop_and_freeze();

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("ran %0d instructions, checked %0d results (%0d with output), %0d length writes",
                 instrs_sent, results_seen, puts_seen, length_writes);
        $display("machine stopped by %s and held its state afterwards", stop_label);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
